/* rtl/core/bra_pkg.sv */
// Package: shared types and constants of the bitmap run allocator.
`default_nettype none

package bra_pkg;

    // Field widths of the item and result transactions
    localparam int IDX_W = 10;
    localparam int LEN_W = 11;

    // Reset value of the bytes-in-use register
    localparam logic [7:0] BYTES_RST = 8'd128;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_TEST   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_WRITE  = 2'd3
    } t_opcode;

    // Input item
    typedef struct packed {
        t_opcode            opcode;
        logic [IDX_W-1:0]   bit_index;
        logic               bit_value;
        logic [LEN_W-1:0]   run_length;
    } t_item;

    // Result item
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   run_start;
        logic               bit_state;
    } t_result;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // latch item, rewind counters, issue first read
        logic init;     // clear one byte of the post-reset sweep
        logic clear;    // clear one managed byte
        logic access;   // finish a test or write
        logic scan;     // advance the first-fit scan
        logic emit;     // register the result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic init_last;
        logic clear_last;
        logic scan_hit;
        logic scan_end;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/bitmap_run_allocator_unit.sv */
// Top level: first-fit bitmap run allocator.
//
//  Channel  Direction  Handshake                      Payload
//  item     in         start high, busy low           i_item   (t_item)
//  result   out        o_done strobe, one cycle       o_result (t_result)
//  config   in         i_cfg_valid and o_cfg_ready    i_cfg_data (bytes in use)
//
// Busy covers the work; the result sits on the ports in the cycle after it.
// Test and write read the byte at the accepting edge; write writes it back in the access state.
// Clear all stays busy while it clears the managed bytes, and enters the clear state even with none.
// Search fetches one byte per cycle over the clamped byte count and stops early on
// a fit; it ends without a fetch when the run length or the byte count is zero.
// After reset all MAX_BYTES bytes of the bitmap are swept to zero with busy high.
`default_nettype none

module bitmap_run_allocator_unit import bra_pkg::*; #(
    parameter int MAX_BYTES = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    output logic            o_done,
    output t_result         o_result,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Always take configuration writes
    assign o_cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_item.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    bra_datapath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/bra_ctrl.sv */
// Controller: state machine sequencing sweeps, bit access and scans.
`default_nettype none

module bra_ctrl import bra_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_opcode i_opcode,
    input  wire t_sts    i_sts,
    output t_cmd         o_cmd,
    output logic         busy
);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_CLEAR  = 5'b00100,
        S_ACCESS = 5'b01000,
        S_SEARCH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode) inside
                        OP_CLEAR:          n_state = S_CLEAR;
                        OP_SEARCH:         n_state = S_SEARCH;
                        OP_TEST, OP_WRITE: n_state = S_ACCESS;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_ACCESS: begin
                o_cmd.access = 1'b1;
                o_cmd.emit   = 1'b1;
                n_state      = S_IDLE;
            end
            S_SEARCH: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bra_datapath.sv */
// Datapath: bitmap memory, configuration register, scan counters and result register.
`default_nettype none

module bra_datapath import bra_pkg::*; #(
    parameter int MAX_BYTES = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_item      i_item,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    output logic            o_done,
    output t_result         o_result
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int EW = (CW > 8) ? CW : 8;
    localparam int IW = (CW > IDX_W - 3) ? CW : IDX_W - 3;
    localparam int PW = AW + 3;
    localparam int SW = (PW > LEN_W) ? PW : LEN_W;

    logic [7:0]        r_bytes_in_use;
    logic [CW-1:0]     managed;

    logic [7:0]        r_mem [MAX_BYTES];
    logic [7:0]        r_rdata;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        wr_mask;

    t_item             r_item;
    logic [CW-1:0]     r_addr;
    logic [CW-1:0]     n_addr;
    logic [AW-1:0]     r_eaddr;
    logic              r_eval;
    logic              n_eval;
    logic [LEN_W-1:0]  r_count;
    logic [LEN_W-1:0]  n_count;

    logic              in_rng_in;
    logic              in_rng;
    logic              issue_more;
    logic              issue;

    logic [LEN_W-1:0]  cnt;
    logic              hit;
    logic [2:0]        hit_j;
    logic [PW-1:0]     pos;
    logic [SW-1:0]     diff;
    logic [IDX_W-1:0]  start_idx;

    logic              r_done;
    t_result           r_result;
    t_result           n_result;

    // Clamp the configured byte count to the bitmap size
    assign managed = (EW'(r_bytes_in_use) > EW'(MAX_BYTES)) ? CW'(MAX_BYTES)
                                                             : CW'(r_bytes_in_use);

    // Range checks on the incoming and the held bit index
    assign in_rng_in = IW'(i_item.bit_index[IDX_W-1:3]) < IW'(managed);
    assign in_rng    = IW'(r_item.bit_index[IDX_W-1:3]) < IW'(managed);

    // Scan issue control
    assign issue_more = (r_addr < managed) && (r_item.run_length != '0);
    assign issue      = i_cmd.scan && issue_more;

    // Select read port
    assign rd_en   = (i_cmd.load && in_rng_in) || issue;
    assign rd_addr = i_cmd.load ? AW'(i_item.bit_index[IDX_W-1:3]) : r_addr[AW-1:0];

    // Select write port
    assign wr_mask = 8'd1 << r_item.bit_index[2:0];
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr[AW-1:0];
        wr_data = '0;
        if (i_cmd.init) begin
            wr_en = 1'b1;
        end else if (i_cmd.clear) begin
            wr_en = r_addr < managed;
        end else if (i_cmd.access) begin
            wr_en   = (r_item.opcode == OP_WRITE) && in_rng;
            wr_addr = AW'(r_item.bit_index[IDX_W-1:3]);
            wr_data = r_item.bit_value ? (r_rdata | wr_mask) : (r_rdata & ~wr_mask);
        end
    end

    // Bitmap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Count free bits across the fetched byte, stop at the first fit
    always_comb begin
        cnt   = r_count;
        hit   = 1'b0;
        hit_j = '0;
        for (int j = 0; j < 8; j++) begin
            if (!hit) begin
                if (r_rdata[j]) begin
                    cnt = '0;
                end else begin
                    cnt = cnt + LEN_W'(1);
                end
                if ((cnt == r_item.run_length) && (r_item.run_length != '0)) begin
                    hit   = 1'b1;
                    hit_j = 3'(j);
                end
            end
        end
    end

    // Start of the run: bit position plus one minus length
    assign pos       = {r_eaddr, hit_j};
    assign diff      = SW'(pos) + SW'(1) - SW'(r_item.run_length);
    assign start_idx = diff[IDX_W-1:0];

    // Report status
    assign o_sts.init_last  = r_addr == CW'(MAX_BYTES - 1);
    assign o_sts.clear_last = (r_addr + CW'(1)) >= managed;
    assign o_sts.scan_hit   = r_eval && hit;
    assign o_sts.scan_end   = !r_eval && !issue_more;

    // Advance counters
    always_comb begin
        n_addr  = r_addr;
        n_eval  = issue;
        n_count = r_count;
        if (i_cmd.load) begin
            n_addr  = '0;
            n_eval  = 1'b0;
            n_count = '0;
        end else begin
            if (i_cmd.init || i_cmd.clear || issue) begin
                n_addr = r_addr + CW'(1);
            end
            if (r_eval) begin
                n_count = cnt;
            end
        end
    end

    // Assemble the result transaction
    always_comb begin
        n_result = '0;
        case (r_item.opcode)
            OP_TEST: begin
                n_result.bit_state = in_rng ? r_rdata[r_item.bit_index[2:0]] : 1'b0;
            end
            OP_SEARCH: begin
                n_result.found     = o_sts.scan_hit;
                n_result.run_start = o_sts.scan_hit ? start_idx : '0;
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_use <= BYTES_RST;
            r_addr         <= '0;
            r_eval         <= 1'b0;
            r_count        <= '0;
            r_done         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bytes_in_use <= i_cfg_data;
            end
            r_addr  <= n_addr;
            r_eval  <= n_eval;
            r_count <= n_count;
            r_done  <= i_cmd.emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (issue) begin
            r_eaddr <= r_addr[AW-1:0];
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* tb/sv/tb_bitmap_run_allocator_unit.sv */
// Testbench for the first-fit bitmap run allocator: random and directed items, scoreboard.
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_unit import bra_pkg::*; ();

    localparam int NBYTES     = 128;
    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = NBYTES + 20;

    // Bitmap shadow, first-fit prediction and the queue of answers still due
    class alloc_scoreboard;
        logic [7:0] occ [NBYTES];
        logic [7:0] bytes_reg;
        t_result    answers_due[$];
        int         mismatches;

        function new();
            foreach (occ[i]) occ[i] = 8'h00;
            bytes_reg  = BYTES_RST;
            mismatches = 0;
        endfunction

        function void set_bytes(logic [7:0] value);
            bytes_reg = value;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Apply one item to the shadow bitmap and return the answer it gives
        function t_result answer(t_item it);
            t_result r;
            int managed;
            int total;
            int first;
            int run;
            int b;
            r = '0;
            managed = (bytes_reg > 8'(NBYTES)) ? NBYTES : int'(bytes_reg);
            total = managed * 8;
            case (it.opcode)
                OP_CLEAR: begin
                    for (b = 0; b < managed; b++) occ[b] = 8'h00;
                end
                OP_TEST: begin
                    if (int'(it.bit_index) < total)
                        r.bit_state = occ[it.bit_index >> 3][it.bit_index[2:0]];
                end
                OP_SEARCH: begin
                    if (it.run_length != '0) begin
                        // skip leading full bytes, then count free bits
                        first = 0;
                        while (first < managed && occ[first] == 8'hff) first++;
                        run = 0;
                        for (b = first * 8; b < total && !r.found; b++) begin
                            if (occ[b >> 3][b % 8] == 1'b0) run++;
                            else run = 0;
                            if (run == int'(it.run_length)) begin
                                r.found     = 1'b1;
                                r.run_start = IDX_W'(b + 1 - run);
                            end
                        end
                    end
                end
                OP_WRITE: begin
                    if (int'(it.bit_index) < total)
                        occ[it.bit_index >> 3][it.bit_index[2:0]] = it.bit_value;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(t_item it);
            answers_due.push_back(answer(it));
        endfunction

        function void check_answer(t_result got);
            t_result want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d start=%0d state=%0d",
                             got.found, got.run_start, got.bit_state);
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found || got.run_start !== want.run_start ||
                got.bit_state !== want.bit_state) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result mismatch: expected found=%0d start=%0d state=%0d, ",
                           want.found, want.run_start, want.bit_state);
                    $display("got found=%0d start=%0d state=%0d",
                             got.found, got.run_start, got.bit_state);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      item_r;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    alloc_scoreboard sb = new();
    int  idle_cycles;
    bit  burst_mode;
    int  managed_now;

    bitmap_run_allocator_unit #(.MAX_BYTES(NBYTES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item_r),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check results first, then note the transaction taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_answer(o_result);
            if (start && !busy) sb.note_item(item_r);
            if (i_cfg_valid && o_cfg_ready) sb.set_bytes(i_cfg_data);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_MAX) begin
                $display("bitmap_run_allocator_unit test failed");
                $finish;
            end
        end
    end

    function automatic t_item mk(t_opcode op, int idx, int val, int len);
        t_item it;
        it.opcode     = op;
        it.bit_index  = IDX_W'(idx);
        it.bit_value  = val[0];
        it.run_length = LEN_W'(len);
        return it;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold start high until the item is taken; return at the accepting edge
    task automatic send_item(t_item it);
        start  <= 1'b1;
        item_r <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic apply(t_item it);
        send_item(it);
        pause(pick_gap());
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the register once every answer is in
    task automatic write_bytes(logic [7:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        managed_now = (value > 8'(NBYTES)) ? NBYTES : int'(value);
    endtask

    function automatic int pick_index(int total);
        if (total > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, total - 1);
        return $urandom_range(0, 1023);
    endfunction

    // Mostly runs of writes and searches over the managed bits, some noise
    task automatic random_phase(int count);
        int sent;
        int total;
        int kind;
        int s;
        int k;
        int val;
        int len;
        int j;
        sent = 0;
        total = managed_now * 8;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // fill or free a run, sometimes from bit 0 to build full bytes
                s = (total > 0 && $urandom_range(0, 2) == 0) ? 0 : pick_index(total);
                k = $urandom_range(1, 24);
                val = ($urandom_range(0, 9) < 8) ? 1 : 0;
                for (j = 0; j < k && sent < count; j++) begin
                    apply(mk(OP_WRITE, (s + j) & 1023, val, 0));
                    sent++;
                end
            end else begin
                if (kind < 60) begin
                    len = $urandom_range(0, 99);
                    if (len < 60) len = $urandom_range(1, 12);
                    else if (len < 85) len = $urandom_range(1, (total > 0) ? total + 1 : 8);
                    else if (len < 95) len = $urandom_range(0, 2047);
                    else len = 0;
                    apply(mk(OP_SEARCH, $urandom_range(0, 1023), $urandom_range(0, 1), len));
                end else if (kind < 75) begin
                    apply(mk(OP_TEST, pick_index(total), $urandom_range(0, 1), 0));
                end else if (kind < 90) begin
                    apply(mk(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1),
                             $urandom_range(0, 2047)));
                end else if (kind < 95) begin
                    apply(mk(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1),
                             $urandom_range(0, 2047)));
                end else begin
                    apply(mk(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 1023),
                             $urandom_range(0, 1), $urandom_range(0, 2047)));
                end
                sent++;
            end
        end
    endtask

    logic [7:0] phase_bytes [11];

    initial begin
        int i;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        item_r      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        burst_mode  = 1'b0;
        managed_now = NBYTES;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero and oversize runs, full leading byte
        apply(mk(OP_WRITE, 0, 1, 0));
        apply(mk(OP_TEST, 0, 0, 0));
        apply(mk(OP_WRITE, 1023, 1, 2047));
        apply(mk(OP_TEST, 1023, 1, 0));
        apply(mk(OP_SEARCH, 0, 0, 0));
        apply(mk(OP_SEARCH, 0, 0, 1));
        apply(mk(OP_SEARCH, 0, 0, 1024));
        apply(mk(OP_WRITE, 0, 0, 0));
        apply(mk(OP_SEARCH, 1023, 1, 1023));
        for (i = 0; i < 8; i++) apply(mk(OP_WRITE, i, 1, 0));
        apply(mk(OP_SEARCH, 0, 0, 1));
        apply(mk(OP_WRITE, 100, 1, 0));

        // One managed byte: clear leaves the rest, indices beyond are ignored
        write_bytes(8'd1);
        apply(mk(OP_CLEAR, 0, 0, 0));
        apply(mk(OP_TEST, 100, 0, 0));
        apply(mk(OP_WRITE, 100, 0, 0));
        apply(mk(OP_SEARCH, 0, 0, 8));
        apply(mk(OP_SEARCH, 0, 0, 9));

        // Nothing managed
        write_bytes(8'd0);
        apply(mk(OP_SEARCH, 0, 0, 1));
        apply(mk(OP_WRITE, 0, 1, 0));
        apply(mk(OP_TEST, 0, 0, 0));

        // Clamped register; bit 100 must have survived
        write_bytes(8'd200);
        apply(mk(OP_TEST, 100, 0, 0));

        phase_bytes = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd129, 8'd2, 8'd16,
                        8'($urandom_range(3, 127)), 8'($urandom_range(0, 255)),
                        8'd64, 8'd128};
        for (i = 0; i < 11; i++) begin
            write_bytes(phase_bytes[i]);
            burst_mode = (i % 3 == 0);
            random_phase(64);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("bitmap_run_allocator_unit test passed");
        end else begin
            $display("bitmap_run_allocator_unit test failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/bra_pkg.sv
rtl/core/bra_ctrl.sv
rtl/core/bra_datapath.sv
rtl/core/bitmap_run_allocator_unit.sv
tb/sv/tb_bitmap_run_allocator_unit.sv
